/* design/stbl_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the sorted table block.
// No dependencies; imported by the interfaces, the cell and the top level.
package stbl_pkg;

	localparam int CAPACITY_DEF  = 16;
	localparam int KEY_WIDTH_DEF = 16;

	localparam int FUNC_W = 2;
	localparam int KEY_W  = 16;
	localparam int POS_W  = 5;
	localparam int CNT_W  = 5;

	localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_LOCATE = 2'd2;

	// Broadcast control from the sequencer to every cell of the row
	typedef struct packed {
		logic ins;
		logic rem;
	} cell_ctl_t;

endpackage

/* design/stbl_in_if.sv */
`timescale 1ns / 1ps
// Request channel: operation code and key with a valid/ready handshake.
// Depends on stbl_pkg for the field widths.
interface stbl_in_if import stbl_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [FUNC_W-1:0] func;
	logic [KEY_W-1:0]  key;

	modport source (output valid, output func, output key, input ready);
	modport sink   (input valid, input func, input key, output ready);
endinterface

/* design/stbl_out_if.sv */
`timescale 1ns / 1ps
// Result channel: ok, found, position and count with a valid/ready handshake.
// Depends on stbl_pkg for the field widths.
interface stbl_out_if import stbl_pkg::*; ();
	logic             valid;
	logic             ready;
	logic             ok;
	logic             found;
	logic [POS_W-1:0] position;
	logic [CNT_W-1:0] count;

	modport source (output valid, output ok, output found, output position,
		output count, input ready);
	modport sink   (input valid, input ok, input found, input position,
		input count, output ready);
endinterface

/* design/stbl_cell.sv */
`timescale 1ns / 1ps
// One slot of the sorted row: holds a key and its occupancy bit, compares
// against the broadcast key and shifts with its neighbors. Uses stbl_pkg.
module stbl_cell import stbl_pkg::*; #(
	parameter int KEY_WIDTH = KEY_WIDTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cell_ctl_t            ctl,
	input  logic [KEY_WIDTH-1:0] key,
	input  logic [KEY_WIDTH-1:0] prev_entry,
	input  logic                 prev_valid,
	input  logic                 prev_lt,
	input  logic [KEY_WIDTH-1:0] next_entry,
	input  logic                 next_valid,
	output logic [KEY_WIDTH-1:0] entry,
	output logic                 valid,
	output logic                 lt,
	output logic                 eq,
	output logic                 boundary
);

	logic [KEY_WIDTH-1:0] entry_q;
	logic                 valid_q;

	assign entry    = entry_q;
	assign valid    = valid_q;
	assign lt       = valid_q && (entry_q < key);
	assign eq       = valid_q && (entry_q == key);
	// first slot not less than the key
	assign boundary = !lt && prev_lt;

	always_ff @(posedge clk) begin
		if (ctl.ins && !lt) begin
			entry_q <= prev_lt ? key : prev_entry;
		end else if (ctl.rem && !lt) begin
			entry_q <= next_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.ins && !lt) begin
			valid_q <= prev_valid;
		end else if (ctl.rem && !lt) begin
			valid_q <= next_valid;
		end
	end

endmodule

/* design/sorted_table_insert_remove_core.sv */
`timescale 1ns / 1ps
// Sorted key table built from a row of compare-and-shift cells.
// A request is held in an input register, and its result is registered in the result register.
// Throughput: one item per cycle while results are taken; each item compares against every cell and
// the row shifts in the cycle the item leaves its input register.
// Reset clears the entry count and every cell's occupancy bit; keys are not reset.
module sorted_table_insert_remove_core import stbl_pkg::*; #(
	parameter int CAPACITY  = CAPACITY_DEF,
	parameter int KEY_WIDTH = KEY_WIDTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	stbl_in_if.sink    req,
	stbl_out_if.source rsp
);

	localparam int IDX_W = $clog2(CAPACITY + 1);

	// request stage
	logic              busy_s1;
	logic [FUNC_W-1:0] func_s1;
	logic [KEY_W-1:0]  key_s1;

	// result register
	logic             out_valid_q;
	logic             ok_q;
	logic             found_q;
	logic [POS_W-1:0] pos_q;
	logic [CNT_W-1:0] cnt_q;

	logic [IDX_W-1:0] count_q;
	logic [IDX_W-1:0] count_nxt;

	logic                 advance;
	logic                 full;
	logic                 found;
	logic                 do_ins;
	logic                 do_rem;
	logic [IDX_W-1:0]     idx;
	logic [KEY_WIDTH-1:0] key_ext;
	cell_ctl_t            ctl;

	logic [KEY_WIDTH-1:0] entry_w [CAPACITY];
	logic [CAPACITY-1:0]  valid_w;
	logic [CAPACITY-1:0]  lt_w;
	logic [CAPACITY-1:0]  eq_w;
	logic [CAPACITY-1:0]  bnd_w;

	// key is zero-extended, or taken in its low KEY_WIDTH bits when KEY_WIDTH is narrower
	generate
		if (KEY_WIDTH >= KEY_W) begin : g_key_wide
			assign key_ext = KEY_WIDTH'(key_s1);
		end else begin : g_key_narrow
			assign key_ext = key_s1[KEY_WIDTH-1:0];
		end
	endgenerate

	assign advance   = busy_s1 && (!out_valid_q || rsp.ready);
	assign req.ready = !busy_s1 || advance;

	assign full   = (count_q == IDX_W'(CAPACITY));
	assign found  = |eq_w;
	assign do_ins = advance && (func_s1 == FUNC_INSERT) && !full;
	assign do_rem = advance && (func_s1 == FUNC_REMOVE) && found;

	assign ctl.ins = do_ins;
	assign ctl.rem = do_rem;

	always_comb begin
		idx = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			if (bnd_w[i]) begin
				idx = idx | IDX_W'(i);
			end
		end
		// every held entry is less than the key on a full row
		if (lt_w[CAPACITY-1]) begin
			idx = IDX_W'(CAPACITY);
		end
	end

	always_comb begin
		count_nxt = count_q;
		if (do_ins) begin
			count_nxt = count_q + IDX_W'(1);
		end else if (do_rem) begin
			count_nxt = count_q - IDX_W'(1);
		end
	end

	genvar g;
	generate
		for (g = 0; g < CAPACITY; g++) begin : g_cell
			logic [KEY_WIDTH-1:0] p_entry;
			logic                 p_valid;
			logic                 p_lt;
			logic [KEY_WIDTH-1:0] n_entry;
			logic                 n_valid;

			if (g == 0) begin : g_first
				assign p_entry = key_ext;
				assign p_valid = 1'b1;
				assign p_lt    = 1'b1;
			end else begin : g_mid
				assign p_entry = entry_w[g-1];
				assign p_valid = valid_w[g-1];
				assign p_lt    = lt_w[g-1];
			end

			if (g == CAPACITY - 1) begin : g_last
				assign n_entry = entry_w[g];
				assign n_valid = 1'b0;
			end else begin : g_inner
				assign n_entry = entry_w[g+1];
				assign n_valid = valid_w[g+1];
			end

			stbl_cell #(
				.KEY_WIDTH(KEY_WIDTH)
			) u_cell (
				.clk        (clk),
				.arst_n     (arst_n),
				.ctl        (ctl),
				.key        (key_ext),
				.prev_entry (p_entry),
				.prev_valid (p_valid),
				.prev_lt    (p_lt),
				.next_entry (n_entry),
				.next_valid (n_valid),
				.entry      (entry_w[g]),
				.valid      (valid_w[g]),
				.lt         (lt_w[g]),
				.eq         (eq_w[g]),
				.boundary   (bnd_w[g])
			);
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_s1     <= 1'b0;
			out_valid_q <= 1'b0;
			count_q     <= '0;
		end else begin
			if (req.valid && req.ready) begin
				busy_s1 <= 1'b1;
			end else if (advance) begin
				busy_s1 <= 1'b0;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			count_q <= count_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			func_s1 <= req.func;
			key_s1  <= req.key;
		end
		if (advance) begin
			ok_q    <= (func_s1 == FUNC_INSERT) ? !full : found;
			found_q <= found;
			pos_q   <= POS_W'({1'b0, idx} + (IDX_W + 1)'(1));
			cnt_q   <= CNT_W'(count_nxt);
		end
	end

	assign rsp.valid    = out_valid_q;
	assign rsp.ok       = ok_q;
	assign rsp.found    = found_q;
	assign rsp.position = pos_q;
	assign rsp.count    = cnt_q;

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 1ps
// Self-checking bench for sorted_table_insert_remove_core: predicts every result
// from its own copy of the sorted key table and checks results in order.
// Depends on stbl_pkg, stbl_in_if and stbl_out_if from the design folder.
module tb_top import stbl_pkg::*; ();

	localparam logic [FUNC_W-1:0] FUNC_SPARE = 2'd3;
	localparam int RANDOM_ITEMS = 1225;
	localparam int CYCLE_LIMIT  = 400000;

	typedef struct packed {
		logic             ok;
		logic             found;
		logic [POS_W-1:0] position;
		logic [CNT_W-1:0] count;
	} table_result_t;

	class sorted_table_checker;
		logic [KEY_W-1:0] keys [CAPACITY_DEF];
		int held;
		table_result_t expected_results [$];
		int failures, reported, checked;
		int n_insert, n_refused, n_remove, n_removed, n_locate;
		int n_full, n_empty, n_past_end;

		// Work out the result of one accepted request and update the table copy.
		function void note_request(logic [FUNC_W-1:0] func, logic [KEY_W-1:0] key);
			int slot;
			int i;
			table_result_t want;
			slot = 0;
			while (slot < held && key > keys[slot])
				slot++;
			want.found = (slot < held) && (keys[slot] == key);
			want.position = POS_W'(slot + 1);
			if (slot == held)
				n_past_end++;
			case (func)
				FUNC_INSERT: begin
					n_insert++;
					want.ok = (held < CAPACITY_DEF);
					if (want.ok) begin
						for (i = held; i > slot; i--)
							keys[i] = keys[i - 1];
						keys[slot] = key;
						held++;
					end else begin
						n_refused++;
					end
				end
				FUNC_REMOVE: begin
					n_remove++;
					want.ok = want.found;
					if (want.ok) begin
						for (i = slot; i + 1 < held; i++)
							keys[i] = keys[i + 1];
						held--;
						n_removed++;
					end
				end
				default: begin
					n_locate++;
					want.ok = want.found;
				end
			endcase
			want.count = CNT_W'(held);
			if (held == CAPACITY_DEF)
				n_full++;
			if (held == 0)
				n_empty++;
			expected_results.push_back(want);
		endfunction

		function void check_result(table_result_t got);
			table_result_t want;
			if (expected_results.size() == 0) begin
				failures++;
				if (reported < 10)
					$display("%0t MISMATCH: result with no request waiting:", $time,
						" ok=%0b found=%0b pos=%0d cnt=%0d",
						got.ok, got.found, got.position, got.count);
				reported++;
			end else begin
				want = expected_results.pop_front();
				checked++;
				if (got !== want) begin
					failures++;
					if (reported < 10)
						$display("%0t MISMATCH: expected ok=%0b found=%0b pos=%0d cnt=%0d,",
							$time, want.ok, want.found, want.position, want.count,
							" got ok=%0b found=%0b pos=%0d cnt=%0d",
							got.ok, got.found, got.position, got.count);
					reported++;
				end
			end
		endfunction

		function int pending();
			return expected_results.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	int   cycles = 0;
	bit   no_idle = 1'b0;

	stbl_in_if  req_ch ();
	stbl_out_if rsp_ch ();

	sorted_table_checker table_check = new();

	sorted_table_insert_remove_core DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles with %0d results outstanding",
				cycles, table_check.pending());
			$display("Some tests failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && req_ch.valid && req_ch.ready)
			table_check.note_request(req_ch.func, req_ch.key);
	end

	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready)
			table_check.check_result({rsp_ch.ok, rsp_ch.found,
				rsp_ch.position, rsp_ch.count});
	end

	function automatic int idle_cycles();
		return no_idle ? 0 : $urandom_range(0, 17);
	endfunction

	// Present one item and hold it until accepted; valid stays high for a back-to-back item.
	task automatic send_item(input logic [FUNC_W-1:0] f, input logic [KEY_W-1:0] k);
		int gap;
		gap = idle_cycles();
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.func  <= f;
		req_ch.key   <= k;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
	endtask

	task automatic run_directed();
		int k;
		send_item(FUNC_LOCATE, 16'h0000);
		send_item(FUNC_REMOVE, 16'h0005);
		send_item(FUNC_SPARE,  16'hFFFF);
		send_item(FUNC_INSERT, 16'hFFFF);
		send_item(FUNC_INSERT, 16'h0000);
		send_item(FUNC_INSERT, 16'h8000);
		send_item(FUNC_INSERT, 16'h8000);
		send_item(FUNC_LOCATE, 16'h8000);
		send_item(FUNC_REMOVE, 16'h8000);
		send_item(FUNC_REMOVE, 16'h7FFF);
		send_item(FUNC_LOCATE, 16'hFFFF);
		send_item(FUNC_SPARE,  16'h0000);
		// fill up to capacity
		for (k = 1; k <= 13; k++)
			send_item(FUNC_INSERT, KEY_W'(k * 16'h1000 + 16'h0123));
		send_item(FUNC_INSERT, 16'h5555);
		send_item(FUNC_REMOVE, 16'hFFFF);
		send_item(FUNC_INSERT, 16'h0001);
		// full table, key above every entry
		send_item(FUNC_INSERT, 16'hFFFF);
	endtask

	task automatic run_random();
		int sent;
		int kind;
		int span;
		int r;
		logic [KEY_W-1:0] base;
		logic [FUNC_W-1:0] f;
		logic [KEY_W-1:0] k;
		sent = 0;
		base = 16'h0000;
		while (sent < RANDOM_ITEMS) begin
			// phases: 0 fill, 1 drain, 2 mixed
			kind = $urandom_range(0, 2);
			span = $urandom_range(20, 60);
			no_idle = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 1) == 0) begin
				case ($urandom_range(0, 3))
					0: base = 16'h0000;
					1: base = 16'hFFF0;
					default: base = KEY_W'($urandom) & 16'hFFF0;
				endcase
			end
			repeat (span) begin
				r = $urandom_range(0, 99);
				if (r < 4)
					f = FUNC_SPARE;
				else if (kind == 0)
					f = (r < 74) ? FUNC_INSERT : (r < 89) ? FUNC_REMOVE : FUNC_LOCATE;
				else if (kind == 1)
					f = (r < 19) ? FUNC_INSERT : (r < 89) ? FUNC_REMOVE : FUNC_LOCATE;
				else
					f = (r < 44) ? FUNC_INSERT : (r < 79) ? FUNC_REMOVE : FUNC_LOCATE;
				if ($urandom_range(0, 3) != 0)
					k = base + KEY_W'($urandom_range(0, 15));
				else
					k = KEY_W'($urandom);
				send_item(f, k);
				sent++;
			end
		end
		req_ch.valid <= 1'b0;
	endtask

	initial begin
		rsp_ch.ready <= 1'b0;
		@(posedge clk);
		while (!arst_n)
			@(posedge clk);
		forever begin : result_sink
			int gap;
			gap = idle_cycles();
			if (gap > 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
			@(posedge clk);
			while (!rsp_ch.valid)
				@(posedge clk);
		end
	end

	initial begin
		arst_n = 1'b0;
		req_ch.valid <= 1'b0;
		req_ch.func  <= FUNC_LOCATE;
		req_ch.key   <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		run_directed();
		run_random();
		while (table_check.pending() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		$display("Covered %0d inserts (%0d refused when full),",
			table_check.n_insert, table_check.n_refused,
			" %0d removes (%0d hits), %0d lookups",
			table_check.n_remove, table_check.n_removed, table_check.n_locate);
		$display("Table full %0d times, empty %0d times, key past last entry %0d times;",
			table_check.n_full, table_check.n_empty, table_check.n_past_end,
			" %0d results checked, %0d mismatches",
			table_check.checked, table_check.failures);
		if (table_check.failures == 0 && table_check.pending() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

/* sorted_table_insert_remove_core.f */
design/stbl_pkg.sv
design/stbl_in_if.sv
design/stbl_out_if.sv
design/stbl_cell.sv
design/sorted_table_insert_remove_core.sv
bench/tb_top.sv
